/* sv/mit_pkg.sv */
// Shared types and constants for the merging interval table.
package mit_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned IN_TDATA_W = 72;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_NEXT = 2'd1;
	localparam logic [1:0] MODE_PREV = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_OVF = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_PREV,
		OP_NEXT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PRED,
		ST_ABSORB,
		ST_WRITE,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

/* sv/merging_interval_table_core.sv */
// Top level of the merging interval table: control sequencer and the row of cells.
//
// Requests arrive on the s_ channel and carry a mode, a revision and a length.
// An add folds the range into a sorted table of disjoint ranges; find next and
// find previous look up the range that covers the revision. Every request gives
// exactly one result on the m_ channel with a status, an answer and the number
// of stored ranges afterwards.
// A find, a zero-length or overflowing add and the unused mode go from the CMP
// and PRED states straight to DONE; any other add also passes ABSORB and WRITE,
// and one that swallows more than one stored range then stays in SHIFT, where the
// table closes the gap by moving every cell one place towards its neighbour in each
// cycle. One request is in progress at a time; s_tready is high only when the
// sequencer is idle, so the next request is taken only after a result is registered.
// The result waits in an output register; while the receiver stalls the block
// accepts one further request, works it out and then holds it, taking nothing
// more until the waiting result has been taken.
// Reset empties the table at once by clearing the range count; the cells
// themselves are not cleared and are never read before they are written.
module merging_interval_table_core #(
	parameter int unsigned RANGE_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// mode [1:0], revision [33:2], length [65:34], zero fill [71:66]
	input  logic [mit_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status [1:0], answer [33:2], range_count [40:34], zero fill [47:41]
	output logic [mit_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int unsigned IW = $clog2(RANGE_SLOTS);
	localparam int unsigned CW = $clog2(RANGE_SLOTS + 1);
	localparam int unsigned DW = mit_pkg::DATA_W;

	mit_pkg::state_t state_q, state_nx;

	logic [1:0]    mode_q;
	logic [DW-1:0] s_q;
	logic          zero_q;
	logic [DW:0]   e_q;
	logic [CW-1:0] n_q;
	logic [RANGE_SLOTS-1:0] lt_q, le_q;
	logic          pm_q;
	logic [CW-1:0] ipos_q, first_q, rem_q, steps_q;
	logic [DW-1:0] ns_q;
	logic [DW:0]   eb_q, efin_q;
	logic [1:0]    res_status_q;
	logic [DW-1:0] res_answer_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [DW-1:0] out_answer_q;
	logic [mit_pkg::COUNT_W-1:0] out_count_q;

	logic [DW-1:0] cstart [RANGE_SLOTS];
	logic [DW-1:0] clen [RANGE_SLOTS];
	logic [DW:0]   cend [RANGE_SLOTS];
	logic [RANGE_SLOTS-1:0] clt, cle, valid;
	mit_pkg::cell_op_t cop [RANGE_SLOTS];

	logic [RANGE_SLOTS-1:0] pred_oh, hit_oh, ab, last_oh;
	logic          pred_any, hit_any, ab_any;
	logic [IW-1:0] pidx, lidx;
	logic [DW-1:0] ps, hs;
	logic [DW:0]   pe, he, le_end;
	logic          pm;
	logic [DW:0]   eb;
	logic [CW-1:0] cnt;
	logic          full;
	logic [CW+mit_pkg::COUNT_W-1:0] cnt_ext;

	assign full = (rem_q == '0) && (n_q == CW'(RANGE_SLOTS));

	for (genvar k = 0; k < RANGE_SLOTS; k++) begin : g_cell
		localparam int unsigned KP = (k == 0) ? 0 : k - 1;
		localparam int unsigned KN = (k == RANGE_SLOTS - 1) ? k : k + 1;
		mit_cell u_cell (
			.clk         (clk),
			.op          (cop[k]),
			.load_start  (ns_q),
			.load_length (efin_q[DW-1:0] - ns_q),
			.prev_start  (cstart[KP]),
			.prev_length (clen[KP]),
			.next_start  (cstart[KN]),
			.next_length (clen[KN]),
			.key         (s_q),
			.start       (cstart[k]),
			.length      (clen[k]),
			.end_pos     (cend[k]),
			.lt          (clt[k]),
			.le          (cle[k])
		);
		assign valid[k] = CW'(k) < n_q;
	end

	always_comb begin
		pred_any = 1'b0;
		hit_any = 1'b0;
		ab_any = 1'b0;
		pidx = '0;
		lidx = '0;
		ps = '0;
		pe = '0;
		hs = '0;
		he = '0;
		le_end = '0;
		for (int k = 0; k < RANGE_SLOTS; k++) begin
			if (k == RANGE_SLOTS - 1) begin
				pred_oh[k] = lt_q[k];
				hit_oh[k] = le_q[k];
			end else begin
				pred_oh[k] = lt_q[k] & ~lt_q[k+1];
				hit_oh[k] = le_q[k] & ~le_q[k+1];
			end
			ab[k] = ~lt_q[k] & valid[k] & ({1'b0, cstart[k]} <= eb_q);
		end
		for (int k = 0; k < RANGE_SLOTS; k++) begin
			if (k == RANGE_SLOTS - 1) begin
				last_oh[k] = ab[k];
			end else begin
				last_oh[k] = ab[k] & ~ab[k+1];
			end
			pred_any = pred_any | pred_oh[k];
			hit_any = hit_any | hit_oh[k];
			ab_any = ab_any | ab[k];
			pidx = pidx | (pred_oh[k] ? IW'(k) : '0);
			lidx = lidx | (last_oh[k] ? IW'(k) : '0);
			ps = ps | (pred_oh[k] ? cstart[k] : '0);
			pe = pe | (pred_oh[k] ? cend[k] : '0);
			hs = hs | (hit_oh[k] ? cstart[k] : '0);
			he = he | (hit_oh[k] ? cend[k] : '0);
			le_end = le_end | (last_oh[k] ? cend[k] : '0);
		end
		pm = pred_any && (pe >= {1'b0, s_q});
		eb = (pm && (pe > e_q)) ? pe : e_q;
		cnt = ab_any ? CW'({1'b0, lidx} + 1'b1 - {1'b0, ipos_q}) : '0;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mit_pkg::ST_IDLE: if (s_tvalid) state_nx = mit_pkg::ST_CMP;
			mit_pkg::ST_CMP: state_nx = mit_pkg::ST_PRED;
			mit_pkg::ST_PRED: begin
				if (mode_q == mit_pkg::MODE_ADD && !zero_q && !e_q[DW]) begin
					state_nx = mit_pkg::ST_ABSORB;
				end else begin
					state_nx = mit_pkg::ST_DONE;
				end
			end
			mit_pkg::ST_ABSORB: state_nx = mit_pkg::ST_WRITE;
			mit_pkg::ST_WRITE: begin
				if (!full && rem_q > CW'(1)) state_nx = mit_pkg::ST_SHIFT;
				else state_nx = mit_pkg::ST_DONE;
			end
			mit_pkg::ST_SHIFT: if (steps_q == CW'(1)) state_nx = mit_pkg::ST_DONE;
			mit_pkg::ST_DONE: if (!out_valid_q || m_tready) state_nx = mit_pkg::ST_IDLE;
			default: state_nx = mit_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == mit_pkg::ST_IDLE);
		for (int k = 0; k < RANGE_SLOTS; k++) begin
			cop[k] = mit_pkg::OP_HOLD;
			if (state_q == mit_pkg::ST_WRITE && !full) begin
				if (CW'(k) == first_q) cop[k] = mit_pkg::OP_LOAD;
				else if (rem_q == '0 && CW'(k) > first_q) cop[k] = mit_pkg::OP_PREV;
			end else if (state_q == mit_pkg::ST_SHIFT && CW'(k) > first_q) begin
				cop[k] = mit_pkg::OP_NEXT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mit_pkg::ST_IDLE;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == mit_pkg::ST_WRITE && !full) begin
				if (rem_q == '0) n_q <= n_q + 1'b1;
				else n_q <= n_q - rem_q + 1'b1;
			end
			if (state_q == mit_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mit_pkg::ST_IDLE: begin
				mode_q <= s_tdata[1:0];
				s_q <= s_tdata[33:2];
				zero_q <= (s_tdata[65:34] == '0);
				e_q <= {1'b0, s_tdata[33:2]} + {1'b0, s_tdata[65:34]};
			end
			mit_pkg::ST_CMP: begin
				lt_q <= clt & valid;
				le_q <= cle & valid;
			end
			mit_pkg::ST_PRED: begin
				pm_q <= pm;
				eb_q <= eb;
				ns_q <= pm ? ps : s_q;
				ipos_q <= pred_any ? CW'({1'b0, pidx} + 1'b1) : '0;
				first_q <= pred_any ? (pm ? CW'(pidx) : CW'({1'b0, pidx} + 1'b1)) : '0;
				res_answer_q <= '0;
				res_status_q <= mit_pkg::STAT_OK;
				if (mode_q == mit_pkg::MODE_ADD) begin
					if (!zero_q && e_q[DW]) res_status_q <= mit_pkg::STAT_OVF;
				end else if (mode_q == mit_pkg::MODE_NEXT || mode_q == mit_pkg::MODE_PREV) begin
					if (!hit_any || he <= {1'b0, s_q}) begin
						res_status_q <= mit_pkg::STAT_MISS;
					end else if (mode_q == mit_pkg::MODE_NEXT) begin
						res_answer_q <= he[DW-1:0];
					end else begin
						res_answer_q <= hs - 1'b1;
					end
				end
			end
			mit_pkg::ST_ABSORB: begin
				efin_q <= (ab_any && le_end > eb_q) ? le_end : eb_q;
				rem_q <= cnt + CW'(pm_q);
			end
			mit_pkg::ST_WRITE: begin
				steps_q <= rem_q - 1'b1;
				if (full) res_status_q <= mit_pkg::STAT_FULL;
			end
			mit_pkg::ST_SHIFT: steps_q <= steps_q - 1'b1;
			mit_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_status_q <= res_status_q;
					out_answer_q <= res_answer_q;
					out_count_q <= cnt_ext[mit_pkg::COUNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign cnt_ext = {{mit_pkg::COUNT_W{1'b0}}, n_q};
	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, out_count_q, out_answer_q, out_status_q};

endmodule

/* sv/mit_cell.sv */
// One table cell: holds one range and compares its start with the broadcast key.
module mit_cell (
	input  logic                          clk,
	input  mit_pkg::cell_op_t             op,
	input  logic [mit_pkg::DATA_W-1:0]    load_start,
	input  logic [mit_pkg::DATA_W-1:0]    load_length,
	input  logic [mit_pkg::DATA_W-1:0]    prev_start,
	input  logic [mit_pkg::DATA_W-1:0]    prev_length,
	input  logic [mit_pkg::DATA_W-1:0]    next_start,
	input  logic [mit_pkg::DATA_W-1:0]    next_length,
	input  logic [mit_pkg::DATA_W-1:0]    key,
	output logic [mit_pkg::DATA_W-1:0]    start,
	output logic [mit_pkg::DATA_W-1:0]    length,
	output logic [mit_pkg::DATA_W:0]      end_pos,
	output logic                          lt,
	output logic                          le
);

	logic [mit_pkg::DATA_W-1:0] start_q;
	logic [mit_pkg::DATA_W-1:0] length_q;

	always_ff @(posedge clk) begin
		case (op)
			mit_pkg::OP_LOAD: begin
				start_q <= load_start;
				length_q <= load_length;
			end
			mit_pkg::OP_PREV: begin
				start_q <= prev_start;
				length_q <= prev_length;
			end
			mit_pkg::OP_NEXT: begin
				start_q <= next_start;
				length_q <= next_length;
			end
			default: begin
				start_q <= start_q;
				length_q <= length_q;
			end
		endcase
	end

	assign start = start_q;
	assign length = length_q;
	assign end_pos = {1'b0, start_q} + {1'b0, length_q};
	assign lt = start_q < key;
	assign le = start_q <= key;

endmodule
